### sv/fpfl_pkg.sv
// Shared types, codes and constants of the FIFO page free-list allocator.
package fpfl_pkg;

   localparam int PAGE_BYTES_DEF      = 4096;
   localparam int MAX_PAGES_DEF       = 1024;
   localparam int BUFFER_SIZE_RST     = 4194304;

   localparam int ADDR_W  = 48;
   localparam int BS_W    = 23;
   localparam int OP_W    = 2;
   localparam int PNUM_W  = 10;
   localparam int STAT_W  = 2;
   localparam int PIDX_W  = 10;
   localparam int FREE_W  = 12;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 64;
   localparam int REQ_DW  = 64;
   localparam int RSP_DW  = 72;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC    = 2'd0,
      OP_REL_ADDR = 2'd1,
      OP_REL_IDX  = 2'd2,
      OP_XLATE    = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // register select bit of the byte address (registers sit 8 bytes apart)
   typedef enum logic {
      REG_BASE_ADDRESS = 1'b0,
      REG_BUFFER_SIZE  = 1'b1
   } reg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base_address;
      logic [BS_W-1:0]   buffer_size;
      logic              list_clear;
   } cfg_type;

   typedef struct packed {
      status_type        status;
      logic              have;
      logic [FREE_W-1:0] free_count;
   } res_type;

endpackage

### sv/fpfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fpfl_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### sv/fpfl_csr.sv
// Configuration registers and page-count calculation of the allocator.
module fpfl_csr #(
   parameter int PAGE_BYTES = fpfl_pkg::PAGE_BYTES_DEF,
   parameter int MAX_PAGES  = fpfl_pkg::MAX_PAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fpfl_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [fpfl_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [fpfl_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output fpfl_pkg::cfg_type             cfg,
   output logic [$clog2(MAX_PAGES+1)-1:0] total
);
   import fpfl_pkg::*;

   localparam int CNT_W      = $clog2(MAX_PAGES + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int CEIL_W     = BS_W + 1;
   localparam int RST_PAGES  = (BUFFER_SIZE_RST + PAGE_BYTES - 1) / PAGE_BYTES;
   localparam int TOTAL_RST  = (RST_PAGES > MAX_PAGES) ? MAX_PAGES : RST_PAGES;

   logic [ADDR_W-1:0] base_address_ff;
   logic [BS_W-1:0]   buffer_size_ff;
   logic [CNT_W-1:0]  total_ff;
   logic              wr_fire;
   reg_type           reg_sel;
   logic [CEIL_W-1:0] ceil_pages;
   logic [CNT_W-1:0]  total_in;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_type'(csr_paddr[3]);
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // ceiling over the page size, capped at the ring depth
   assign ceil_pages = (CEIL_W'(csr_pwdata[BS_W-1:0]) + CEIL_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
   assign total_in   = (ceil_pages > CEIL_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                          : CNT_W'(ceil_pages);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= '0;
         buffer_size_ff  <= BS_W'(BUFFER_SIZE_RST);
         total_ff        <= CNT_W'(TOTAL_RST);
      end else if (wr_fire) begin
         case (reg_sel)
            REG_BASE_ADDRESS: begin
               base_address_ff <= csr_pwdata[ADDR_W-1:0];
            end
            REG_BUFFER_SIZE: begin
               buffer_size_ff <= csr_pwdata[BS_W-1:0];
               total_ff       <= total_in;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_BASE_ADDRESS: csr_prdata = CSR_DW'(base_address_ff);
         REG_BUFFER_SIZE:  csr_prdata = CSR_DW'(buffer_size_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.base_address = base_address_ff;
   assign cfg.buffer_size  = buffer_size_ff;
   assign cfg.list_clear   = wr_fire && (reg_sel == REG_BUFFER_SIZE);
   assign total            = total_ff;

endmodule

### sv/fpfl_engine.sv
// Free-list state, release ring and per-item decision stage.
module fpfl_engine #(
   parameter int PAGE_BYTES = fpfl_pkg::PAGE_BYTES_DEF,
   parameter int MAX_PAGES  = fpfl_pkg::MAX_PAGES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fpfl_pkg::cfg_type              cfg,
   input  logic [$clog2(MAX_PAGES+1)-1:0] total,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  fpfl_pkg::op_type               in_op,
   input  logic [fpfl_pkg::ADDR_W-1:0]    in_addr,
   input  logic [fpfl_pkg::PNUM_W-1:0]    in_pnum,
   output logic                           out_valid,
   input  logic                           out_ready,
   output fpfl_pkg::res_type              out_res,
   output logic [$clog2(MAX_PAGES)-1:0]   out_idx
);
   import fpfl_pkg::*;

   localparam int CNT_W      = $clog2(MAX_PAGES + 1);
   localparam int IDX_W      = $clog2(MAX_PAGES);
   localparam int SUM_W      = CNT_W + 1;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int QW         = (BS_W > CNT_W) ? BS_W : CNT_W;
   localparam int NUM_W      = (CNT_W > PNUM_W) ? CNT_W : PNUM_W;

   function automatic logic [IDX_W-1:0] ring_adv(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(MAX_PAGES - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [CNT_W-1:0] fresh_next_ff, fresh_next_in;
   logic [IDX_W-1:0] ring_head_ff, ring_head_in;
   logic [IDX_W-1:0] ring_tail_ff, ring_tail_in;
   logic [CNT_W-1:0] ring_count_ff, ring_count_in;
   logic             byp_ff;
   logic [IDX_W-1:0] byp_data_ff;
   logic             mid_valid_ff;
   res_type          mid_res_ff, res_in;
   logic [IDX_W-1:0] mid_idx_ff;

   logic             fire;
   logic [ADDR_W:0]  addr_diff;
   logic [ADDR_W-1:0] offset;
   logic [BS_W-1:0]  addr_page;
   logic             addr_ok;
   logic [IDX_W-1:0] addr_idx;
   logic             pnum_ok;
   logic             rel_ok;
   logic [IDX_W-1:0] rel_idx;
   logic [IDX_W-1:0] ram_rdata;
   logic [IDX_W-1:0] head_data;
   logic             ring_full;
   logic             push, pop, fresh_inc;
   logic [IDX_W-1:0] idx;
   logic [SUM_W-1:0] free_sum;
   logic             wr_en;

   assign in_ready = !mid_valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   // address to page index: below base, past the buffer, or past the page count fail
   assign addr_diff = {1'b0, in_addr} - {1'b0, cfg.base_address};
   assign offset    = addr_diff[ADDR_W-1:0];
   assign addr_page = offset[BS_W-1:0] >> PAGE_SHIFT;
   assign addr_ok   = !addr_diff[ADDR_W]
                   && (offset < ADDR_W'(cfg.buffer_size))
                   && (QW'(addr_page) < QW'(total));
   assign addr_idx  = IDX_W'(addr_page);

   assign pnum_ok   = NUM_W'(in_pnum) < NUM_W'(total);
   assign rel_ok    = (in_op == OP_REL_ADDR) ? addr_ok : pnum_ok;
   assign rel_idx   = (in_op == OP_REL_ADDR) ? addr_idx : IDX_W'(in_pnum);

   // head entry: RAM output, or the value written to that slot last cycle
   assign head_data = byp_ff ? byp_data_ff : ram_rdata;
   assign ring_full = ring_count_ff == CNT_W'(MAX_PAGES);

   always_comb begin
      res_in.status = ST_OK;
      res_in.have   = 1'b0;
      idx           = '0;
      push          = 1'b0;
      pop           = 1'b0;
      fresh_inc     = 1'b0;
      case (in_op)
         OP_ALLOC: begin
            if (fresh_next_ff < total) begin
               idx         = IDX_W'(fresh_next_ff);
               res_in.have = 1'b1;
               fresh_inc   = 1'b1;
            end else if (ring_count_ff != '0) begin
               idx         = head_data;
               res_in.have = 1'b1;
               pop         = 1'b1;
            end else begin
               res_in.status = ST_EMPTY;
            end
         end
         OP_XLATE: begin
            if (addr_ok) begin
               idx         = addr_idx;
               res_in.have = 1'b1;
            end else begin
               res_in.status = ST_RANGE;
            end
         end
         OP_REL_ADDR, OP_REL_IDX: begin
            if (!rel_ok) begin
               res_in.status = ST_RANGE;
            end else begin
               idx         = rel_idx;
               res_in.have = 1'b1;
               if (ring_full) begin
                  res_in.status = ST_FULL;
               end else begin
                  push = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      fresh_next_in = fresh_next_ff;
      ring_head_in  = ring_head_ff;
      ring_tail_in  = ring_tail_ff;
      ring_count_in = ring_count_ff;
      if (cfg.list_clear) begin
         fresh_next_in = '0;
         ring_head_in  = '0;
         ring_tail_in  = '0;
         ring_count_in = '0;
      end else if (fire) begin
         if (fresh_inc) begin
            fresh_next_in = fresh_next_ff + 1'b1;
         end
         if (push) begin
            ring_tail_in  = ring_adv(ring_tail_ff);
            ring_count_in = ring_count_ff + 1'b1;
         end
         if (pop) begin
            ring_head_in  = ring_adv(ring_head_ff);
            ring_count_in = ring_count_ff - 1'b1;
         end
      end
   end

   assign free_sum          = SUM_W'(total) - SUM_W'(fresh_next_in) + SUM_W'(ring_count_in);
   assign res_in.free_count = FREE_W'(free_sum);
   assign wr_en             = fire && push && !cfg.list_clear;

   fpfl_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_PAGES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ring_tail_ff),
      .wr_data (idx),
      .rd_addr (ring_head_in),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_next_ff <= '0;
         ring_head_ff  <= '0;
         ring_tail_ff  <= '0;
         ring_count_ff <= '0;
         byp_ff        <= 1'b0;
         mid_valid_ff  <= 1'b0;
      end else begin
         fresh_next_ff <= fresh_next_in;
         ring_head_ff  <= ring_head_in;
         ring_tail_ff  <= ring_tail_in;
         ring_count_ff <= ring_count_in;
         byp_ff        <= wr_en && (ring_tail_ff == ring_head_in);
         if (fire) begin
            mid_valid_ff <= 1'b1;
         end else if (out_ready) begin
            mid_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= idx;
      if (fire) begin
         mid_res_ff <= res_in;
         mid_idx_ff <= idx;
      end
   end

   assign out_valid = mid_valid_ff;
   assign out_res   = mid_res_ff;
   assign out_idx   = mid_idx_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ring_count_ff <= CNT_W'(MAX_PAGES))
      else $error("release ring count above its depth");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_next_ff <= total)
      else $error("fresh page counter passed the page count");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (ring_count_ff == '0) |-> (ring_head_ff == ring_tail_ff))
      else $error("empty ring with head and tail apart");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (fire && pop) |-> (ring_count_ff != '0) && (fresh_next_ff >= total))
      else $error("ring pop while fresh pages remain or ring empty");

endmodule

### sv/fifo_page_free_list_allocator_core.sv
// Top level of the FIFO page free-list allocator: stream ports, input and result registers.
//
// Hands out pages of a buffer at base_address in FIFO order: never-issued pages
// first in index order, then released pages oldest first from a ring of
// MAX_PAGES entries held in a RAM. Each request item (allocate, release by
// address, release by index, translate) gives exactly one result item with a
// status, the page's start address and index, and the free-page count after
// the request. One item is taken every cycle unless the result stream stalls;
// a result passes the input register, the decision stage that updates the
// free list, and the result stage that forms base_address + index * PAGE_BYTES.
// The RAM is addressed with the next ring head, so back-to-back allocates
// from the ring do not stall. The ring needs no clearing pass after
// reset. Writing buffer_size empties the list and recomputes the page count;
// write configuration only while no item is in flight. Registers: base_address
// at byte 0x0, buffer_size at byte 0x8.
module fifo_page_free_list_allocator_core #(
   parameter int PAGE_BYTES = fpfl_pkg::PAGE_BYTES_DEF,
   parameter int MAX_PAGES  = fpfl_pkg::MAX_PAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // operation[1:0], address[49:2], page_number[59:50], zero fill [63:60]
   input  logic [fpfl_pkg::REQ_DW-1:0]   req_tdata,
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // status[1:0], page_address[49:2], page_index[59:50], free_count[71:60]
   output logic [fpfl_pkg::RSP_DW-1:0]   rsp_tdata,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fpfl_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [fpfl_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [fpfl_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import fpfl_pkg::*;

   localparam int CNT_W      = $clog2(MAX_PAGES + 1);
   localparam int IDX_W      = $clog2(MAX_PAGES);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

   cfg_type            cfg;
   logic [CNT_W-1:0]   total;

   // input register
   logic               in_valid_ff;
   op_type             in_op_ff;
   logic [ADDR_W-1:0]  in_addr_ff;
   logic [PNUM_W-1:0]  in_pnum_ff;
   logic               req_fire;

   // decision stage handshake
   logic               eng_in_ready;
   logic               eng_out_valid;
   res_type            eng_res;
   logic [IDX_W-1:0]   eng_idx;

   // result register
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_page_address_ff;
   logic [PIDX_W-1:0]  rsp_page_index_ff;
   logic [FREE_W-1:0]  rsp_free_count_ff;
   logic               rsp_room;
   logic               rsp_load;
   logic [ADDR_W-1:0]  page_address_in;

   fpfl_csr #(
      .PAGE_BYTES (PAGE_BYTES),
      .MAX_PAGES  (MAX_PAGES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .total       (total)
   );

   // Hold the request while the decision stage is busy; take a new one when it moves on.
   assign req_tready = !in_valid_ff || eng_in_ready;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (eng_in_ready) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff   <= op_type'(req_tdata[1:0]);
         in_addr_ff <= req_tdata[49:2];
         in_pnum_ff <= req_tdata[59:50];
      end
   end

   fpfl_engine #(
      .PAGE_BYTES (PAGE_BYTES),
      .MAX_PAGES  (MAX_PAGES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .total     (total),
      .in_valid  (in_valid_ff),
      .in_ready  (eng_in_ready),
      .in_op     (in_op_ff),
      .in_addr   (in_addr_ff),
      .in_pnum   (in_pnum_ff),
      .out_valid (eng_out_valid),
      .out_ready (rsp_room),
      .out_res   (eng_res),
      .out_idx   (eng_idx)
   );

   // Result stage: form the page address; drop to zero when no page is concerned.
   assign rsp_room        = !rsp_valid_ff || rsp_tready;
   assign rsp_load        = eng_out_valid && rsp_room;
   assign page_address_in = cfg.base_address + (ADDR_W'(eng_idx) << PAGE_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff       <= eng_res.status;
         rsp_page_address_ff <= eng_res.have ? page_address_in : '0;
         rsp_page_index_ff   <= eng_res.have ? PIDX_W'(eng_idx) : '0;
         rsp_free_count_ff   <= eng_res.free_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_free_count_ff, rsp_page_index_ff, rsp_page_address_ff,
                        rsp_status_ff};

endmodule

### dv/tb.sv
// Self-checking testbench for the FIFO page free-list allocator core.
`timescale 1ns / 1ps

module tb;
   import fpfl_pkg::*;

   // Result item as the stream carries it, one field per slice of rsp_tdata
   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   page_address;
      logic [PIDX_W-1:0]   page_index;
      logic [FREE_W-1:0]   free_count;
   } page_result_type;

   // Receiver stall patterns, chosen per window of cycles
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_DENSE
   } rx_pattern_type;

   localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DW-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DW-1:0]     rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr = '0;
   logic [CSR_DW-1:0]     csr_pwdata = '0;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   // Shadow of the allocator: configuration, fresh-page counter and release ring
   logic [ADDR_W-1:0]     cfg_base = '0;
   logic [BS_W-1:0]       cfg_size = BS_W'(BUFFER_SIZE_RST);
   int unsigned           fresh_ctr = 0;
   logic [PIDX_W-1:0]     recycle_ring [0:MAX_PAGES_DEF-1];
   int unsigned           recycle_head = 0;
   int unsigned           recycle_tail = 0;
   int unsigned           recycle_cnt = 0;

   // Results predicted for accepted items, oldest first
   page_result_type       pending_pages [$];
   page_result_type       want_rsp;
   int unsigned           mismatch_count = 0;

   // Sender burst shaping
   int unsigned           tx_burst_left = 0;
   int unsigned           tx_gap_max = 12;

   // Receiver stall shaping; a test posts a hold-off length in rx_hold_req
   int unsigned           rx_hold_req = 0;
   int unsigned           rx_hold_left = 0;
   int unsigned           rx_window = 0;
   rx_pattern_type        rx_mode = RX_OPEN;

   fifo_page_free_list_allocator_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Global limit: several times the slowest legal run
   initial begin
      #(5_000_000);
      $display("** fifo_page_free_list_allocator_core: FAILED **");
      $finish;
   end

   // Print one line per mismatch and count every one
   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   // Page count: ceiling of buffer size over page size, capped at the ring depth
   function automatic int unsigned page_count();
      longint unsigned p;
      p = 64'(cfg_size);
      p = (p + PAGE_BYTES_DEF - 1) / PAGE_BYTES_DEF;
      if (p > MAX_PAGES_DEF) p = MAX_PAGES_DEF;
      return int'(p);
   endfunction

   // Map a byte address to its page; zero when it falls outside the buffer
   function automatic bit map_address(input logic [ADDR_W-1:0] a, output int unsigned idx);
      longint unsigned off;
      longint unsigned q;
      idx = 0;
      if (a < cfg_base) return 1'b0;
      off = 64'(a - cfg_base);
      if (off >= 64'(cfg_size)) return 1'b0;
      q = off / PAGE_BYTES_DEF;
      if (q >= 64'(page_count())) return 1'b0;
      idx = int'(q);
      return 1'b1;
   endfunction

   // Apply one request to the shadow allocator and return the result it gives
   function automatic page_result_type predict_page_op(input op_type op,
                                                       input logic [ADDR_W-1:0] addr,
                                                       input logic [PNUM_W-1:0] pnum);
      page_result_type r;
      int unsigned     total;
      int unsigned     idx;
      int unsigned     fc;
      bit              have;
      bit              ok;
      longint unsigned pa;
      longint unsigned step_bytes;
      total = page_count();
      idx = 0;
      have = 1'b0;
      r.status = ST_OK;
      case (op)
         OP_ALLOC: begin
            if (fresh_ctr < total) begin
               idx = fresh_ctr;
               fresh_ctr++;
               have = 1'b1;
            end else if (recycle_cnt > 0) begin
               idx = 32'(recycle_ring[recycle_head]);
               recycle_head = (recycle_head + 1 >= MAX_PAGES_DEF) ? 0 : recycle_head + 1;
               recycle_cnt--;
               have = 1'b1;
            end else begin
               r.status = ST_EMPTY;
            end
         end
         OP_XLATE: begin
            if (map_address(addr, idx)) have = 1'b1;
            else r.status = ST_RANGE;
         end
         default: begin
            if (op == OP_REL_ADDR) begin
               ok = map_address(addr, idx);
            end else begin
               idx = 32'(pnum);
               ok = (32'(pnum) < total);
            end
            if (!ok) begin
               r.status = ST_RANGE;
            end else begin
               have = 1'b1;
               // a full ring rejects the page but still reports it
               if (recycle_cnt >= MAX_PAGES_DEF) begin
                  r.status = ST_FULL;
               end else begin
                  recycle_ring[recycle_tail] = idx[PIDX_W-1:0];
                  recycle_tail = (recycle_tail + 1 >= MAX_PAGES_DEF) ? 0 : recycle_tail + 1;
                  recycle_cnt++;
               end
            end
         end
      endcase
      if (fresh_ctr > total) fresh_ctr = total;
      step_bytes = 64'(idx);
      pa = 64'(cfg_base);
      pa = pa + step_bytes * PAGE_BYTES_DEF;
      r.page_address = have ? pa[ADDR_W-1:0] : '0;
      r.page_index   = have ? idx[PIDX_W-1:0] : '0;
      fc = total - fresh_ctr + recycle_cnt;
      r.free_count = fc[FREE_W-1:0];
      return r;
   endfunction

   // Offer one item, wait for its handshake, record its prediction, then maybe gap
   task automatic send_item(input op_type op, input logic [ADDR_W-1:0] addr,
                            input logic [PNUM_W-1:0] pnum);
      int unsigned     gap;
      page_result_type pred;
      req_tdata  <= {4'b0000, pnum, addr, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = predict_page_op(op, addr, pnum);
      pending_pages.insert(pending_pages.size(), pred);
      if (tx_burst_left != 0) begin
         tx_burst_left--;
      end else begin
         tx_burst_left = $urandom_range(1, 24);
         gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pages.size() != 0) @(posedge clock);
   endtask

   // Idle point: all results in, then a wait for the pipeline to empty
   task automatic settle_block();
      wait_results_done();
      repeat (6) @(posedge clock);
   endtask

   // Write one register through the setup and access cycles, then mirror it
   task automatic csr_write(input reg_type sel, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {sel, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (sel == REG_BASE_ADDRESS) begin
         cfg_base = value[ADDR_W-1:0];
      end else begin
         // a size write empties the free list
         cfg_size     = value[BS_W-1:0];
         fresh_ctr    = 0;
         recycle_head = 0;
         recycle_tail = 0;
         recycle_cnt  = 0;
      end
   endtask

   task automatic configure(input logic [ADDR_W-1:0] base, input logic [BS_W-1:0] size);
      settle_block();
      csr_write(REG_BASE_ADDRESS, {{(CSR_DW-ADDR_W){1'b0}}, base});
      csr_write(REG_BUFFER_SIZE, {{(CSR_DW-BS_W){1'b0}}, size});
   endtask

   // Mostly addresses inside the buffer, the rest just outside it or anywhere
   function automatic logic [ADDR_W-1:0] pick_address();
      longint unsigned a;
      int unsigned     r;
      r = $urandom_range(0, 99);
      a = 64'(cfg_base);
      if (r < 70) a = a + $urandom_range(0, cfg_size - 1);
      else if (r < 80) a = a + cfg_size + $urandom_range(0, 8192);
      else if (r < 90) a = a - 1 - $urandom_range(0, 4096);
      else a = {$urandom, $urandom};
      return a[ADDR_W-1:0];
   endfunction

   function automatic logic [PNUM_W-1:0] pick_page_number();
      int unsigned total;
      total = page_count();
      if (total > 0 && $urandom_range(0, 99) < 80) return PNUM_W'($urandom_range(0, total - 1));
      return PNUM_W'($urandom);
   endfunction

   // Weighted op mix; every field carries random content even where unused
   task automatic run_random_items(input int unsigned count);
      int unsigned r;
      op_type      op;
      for (int unsigned i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) op = OP_ALLOC;
         else if (r < 60) op = OP_REL_ADDR;
         else if (r < 85) op = OP_REL_IDX;
         else op = OP_XLATE;
         if (i == count / 2) wait_results_done();
         send_item(op, pick_address(), pick_page_number());
      end
   endtask

   // Reset state on the default buffer: fresh pages, translate edges, releases
   task automatic test_default_buffer();
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_ALLOC, ADDR_MASK, '1);
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_XLATE, '0, '0);
      send_item(OP_XLATE, 48'h00_0000_3F_FFFF, '0);
      send_item(OP_XLATE, 48'h00_0000_40_0000, '0);
      send_item(OP_XLATE, ADDR_MASK, '0);
      // rounds down to page one
      send_item(OP_REL_ADDR, 48'h0000_0000_1FFF, '0);
      send_item(OP_REL_IDX, '0, 10'd1023);
      send_item(OP_REL_IDX, ADDR_MASK, 10'd1023);
   endtask

   // Three pages with a partial last page: empty list, range checks, double release
   task automatic test_small_buffer();
      configure(48'h0000_0001_0000, 23'd12000);
      repeat (4) send_item(OP_ALLOC, '0, '0);
      send_item(OP_REL_ADDR, cfg_base - 48'd1, '0);
      send_item(OP_REL_IDX, '0, 10'd3);
      send_item(OP_REL_ADDR, cfg_base + 48'd11999, '0);
      send_item(OP_REL_ADDR, cfg_base + 48'd12000, '0);
      send_item(OP_REL_IDX, '0, 10'd0);
      send_item(OP_REL_IDX, '0, 10'd0);
      repeat (4) send_item(OP_ALLOC, '0, '0);
      send_item(OP_XLATE, cfg_base + 48'd4096, '0);
   endtask

   // Release past the ring depth on a two-page buffer, then drain some back out
   task automatic test_ring_overflow();
      configure(48'h0000_00AB_C000, 23'd8192);
      for (int i = 0; i < MAX_PAGES_DEF + 6; i++)
         send_item(OP_REL_IDX, pick_address(), PNUM_W'($urandom_range(0, 1)));
      send_item(OP_REL_ADDR, cfg_base + 48'd5000, '0);
      repeat (12) send_item(OP_ALLOC, '0, '0);
      send_item(OP_REL_IDX, '0, 10'd1);
   endtask

   // Long receiver hold-off while the sender keeps offering, on the largest buffer
   task automatic test_backpressure();
      configure('0, 23'd4194304);
      tx_gap_max = 0;
      rx_hold_req = 300;
      run_random_items(200);
      tx_gap_max = 12;
   endtask

   // Random traffic over extreme and random settings
   task automatic test_random_settings();
      logic [63:0] rnd;
      configure(48'hFFFF_FFFF_F000, 23'd4194304);
      run_random_items(70);
      configure(48'hFFFF_FFFF_FFFF, 23'd1);
      run_random_items(60);
      for (int k = 0; k < 5; k++) begin
         rnd = {$urandom, $urandom};
         tx_gap_max = (k == 2) ? 0 : $urandom_range(1, 16);
         if (k == 4) configure(rnd[ADDR_W-1:0], BS_W'($urandom_range(1, 4194304)));
         else configure(rnd[ADDR_W-1:0] & 48'hFFFF_FFFF_F000,
                        BS_W'($urandom_range(1, 40000)));
         run_random_items(50);
      end
      tx_gap_max = 12;
   endtask

   // Receiver: honor a posted hold-off, otherwise stall on a windowed pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
         end
         if (rx_hold_left != 0) begin
            rx_hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (rx_window == 0) begin
               rx_window = $urandom_range(8, 80);
               rx_mode = rx_pattern_type'($urandom_range(0, 3));
            end else begin
               rx_window--;
            end
            case (rx_mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Checker: compare each accepted result item with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pages.size() == 0) begin
            flag_mismatch($sformatf("result item %h with nothing pending", rsp_tdata));
         end else begin
            want_rsp = pending_pages[0];
            pending_pages.delete(0);
            if (rsp_tdata[1:0] != want_rsp.status)
               flag_mismatch($sformatf("status %0d, want %0d",
                                       rsp_tdata[1:0], want_rsp.status));
            if (rsp_tdata[49:2] != want_rsp.page_address)
               flag_mismatch($sformatf("page_address %h, want %h",
                                       rsp_tdata[49:2], want_rsp.page_address));
            if (rsp_tdata[59:50] != want_rsp.page_index)
               flag_mismatch($sformatf("page_index %0d, want %0d",
                                       rsp_tdata[59:50], want_rsp.page_index));
            if (rsp_tdata[71:60] != want_rsp.free_count)
               flag_mismatch($sformatf("free_count %0d, want %0d",
                                       rsp_tdata[71:60], want_rsp.free_count));
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_buffer();
      test_small_buffer();
      test_ring_overflow();
      test_backpressure();
      test_random_settings();
      // drain, then give late or extra results time to show up
      settle_block();
      repeat (10) @(posedge clock);
      if (pending_pages.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", pending_pages.size()));
      if (mismatch_count == 0) begin
         $display("** fifo_page_free_list_allocator_core: PASSED **");
      end else begin
         $display("** fifo_page_free_list_allocator_core: FAILED **");
      end
      $finish;
   end

endmodule

### fifo_page_free_list_allocator_core.f
sv/fpfl_pkg.sv
sv/fpfl_ram.sv
sv/fpfl_csr.sv
sv/fpfl_engine.sv
sv/fifo_page_free_list_allocator_core.sv
dv/tb.sv
